[rtl/core/feed_sequence_validator_defines.svh]
// Assertion macros shared by the feed sequence validator RTL.
`ifndef FEED_SEQUENCE_VALIDATOR_DEFINES_SVH
`define FEED_SEQUENCE_VALIDATOR_DEFINES_SVH

// Check a property on every rising clk edge outside reset.
`define FSV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define FSV_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/core/fsv_pkg.sv]
// Types, constants and helpers shared by the feed sequence validator.
`default_nettype none

package fsv_pkg;

    localparam int SEQ_W = 63;
    localparam int LAST_W = 64;
    localparam int CNT_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [LAST_W-1:0] NO_PREV = '1;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_GAP    = 2'd1,
        VERDICT_STALE  = 2'd2
    } verdict_t;

    typedef struct packed {
        logic                     is_snapshot;
        logic [SEQ_W-1:0]         event_sequence;
        logic                     prev_present;
        logic signed [LAST_W-1:0] prev_sequence;
        logic                     has_levels;
    } item_t;

    typedef struct packed {
        logic              baseline_valid;
        logic [LAST_W-1:0] last_sequence;
        logic [LAST_W-1:0] arrival_number;
        logic [CNT_W-1:0]  accepted_total;
        logic [CNT_W-1:0]  gap_total;
        logic [CNT_W-1:0]  stale_total;
    } state_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [LAST_W-1:0] effective_sequence;
        logic [CNT_W-1:0]  accepted_count;
        logic [CNT_W-1:0]  gap_count;
        logic [CNT_W-1:0]  stale_count;
    } result_t;

    localparam state_t STATE_RESET = '{
        baseline_valid: 1'b0,
        last_sequence:  NO_PREV,
        arrival_number: '0,
        accepted_total: '0,
        gap_total:      '0,
        stale_total:    '0
    };

    // Saturating increment of a statistics counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

[rtl/core/feed_sequence_validator.sv]
// Top level of the market-data feed sequence validator.
// Path: each request is captured in the input stage, and its result is registered in the result stage.
// Throughput: one request per cycle unless out_stall holds the result stage; the state update
// closes in the decision stage, so the following request always sees the state left by the one before it.
// Reset (rst_n low, asynchronous): pipeline empties, mode returns to sequenced (1),
// baseline clears, last sequence goes to all ones and every counter to zero.
`default_nettype none

`include "feed_sequence_validator_defines.svh"

module feed_sequence_validator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // Configuration write channel: validation mode.
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic                            cfg_data,

    // Request channel.
    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire logic                            is_snapshot,
    input  wire logic [fsv_pkg::SEQ_W-1:0]       event_sequence,
    input  wire logic                            prev_present,
    input  wire logic signed [fsv_pkg::LAST_W-1:0] prev_sequence,
    input  wire logic                            has_levels,

    // Result channel.
    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      logic [1:0]                      verdict,
    output      logic [fsv_pkg::LAST_W-1:0]      effective_sequence,
    output      logic [fsv_pkg::CNT_W-1:0]       accepted_count,
    output      logic [fsv_pkg::CNT_W-1:0]       gap_count,
    output      logic [fsv_pkg::CNT_W-1:0]       stale_count
);
    import fsv_pkg::*;

    // Mode register: 0 numbers arrivals, 1 checks sequence continuity.
    logic    mode_reg;

    // Input stage: holds one captured request.
    logic    item_valid_reg;
    logic    item_valid_next;
    item_t   item_reg;

    // Result stage: output register facing the consumer.
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    // Tracking state, updated as each request leaves the input stage.
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;

    logic    result_free;
    logic    advance;
    logic    in_take;

    // The user must write configuration only while idle; the block does not enforce it and takes every write at once.
    assign cfg_ready = 1'b1;

    // The result register frees up when it is empty or being drained this cycle.
    assign result_free = !out_valid_reg || !out_stall;
    // Advance the captured request into the result register when there is room.
    assign advance     = item_valid_reg && result_free;
    // Stall the producer only while the input stage is full and cannot move on.
    assign in_stall    = item_valid_reg && !result_free;
    assign in_take     = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    fsv_decide u_decide (
        .mode       (mode_reg),
        .item       (item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Control and tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b1;
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= STATE_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: load on the handshake, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.is_snapshot    <= is_snapshot;
            item_reg.event_sequence <= event_sequence;
            item_reg.prev_present   <= prev_present;
            item_reg.prev_sequence  <= prev_sequence;
            item_reg.has_levels     <= has_levels;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign verdict            = result_reg.verdict;
    assign effective_sequence = result_reg.effective_sequence;
    assign accepted_count     = result_reg.accepted_count;
    assign gap_count          = result_reg.gap_count;
    assign stale_count        = result_reg.stale_count;

    // Once a baseline is set it stays set.
    `FSV_ASSERT_NEVER(a_baseline_sticky, $fell(state_reg.baseline_valid), "baseline lost")

    // Arrival numbering accepts every request.
    `FSV_ASSERT(a_arrival_accepts, (advance && !mode_reg) |=> (result_reg.verdict == VERDICT_ACCEPT), "arrival mode gave a non-accept verdict")

    // A delta ahead of any baseline leaves every counter alone.
    `FSV_ASSERT(a_pre_baseline_uncounted, (advance && mode_reg && !item_reg.is_snapshot && !state_reg.baseline_valid) |=> ($stable(state_reg.accepted_total) && $stable(state_reg.gap_total) && $stable(state_reg.stale_total)), "pre-baseline delta was counted")

    // Tracking state only changes when a request leaves the input stage.
    `FSV_ASSERT(a_state_moves_on_advance, !advance |=> $stable(state_reg), "state changed without a request")

endmodule

`default_nettype wire

[rtl/core/fsv_decide.sv]
// Per-request decision logic: verdict, effective sequence and next state.
`default_nettype none

module fsv_decide (
    input  wire logic            mode,
    input  wire fsv_pkg::item_t  item,
    input  wire fsv_pkg::state_t state_cur,
    output fsv_pkg::state_t      state_next,
    output fsv_pkg::result_t     result
);
    import fsv_pkg::*;

    logic [LAST_W-1:0] seq_ext;
    logic              prev_is_none;
    logic              prev_links;
    logic              last_positive;

    assign seq_ext       = {1'b0, item.event_sequence};
    assign prev_is_none  = item.prev_present && ($unsigned(item.prev_sequence) == NO_PREV);
    assign prev_links    = item.prev_present
                           && ($unsigned(item.prev_sequence) == state_cur.last_sequence);
    assign last_positive = (state_cur.last_sequence != '0) && !state_cur.last_sequence[LAST_W-1];

    always_comb
    begin
        state_next                = state_cur;
        result.verdict            = VERDICT_ACCEPT;
        result.effective_sequence = '0;

        if (!mode)
        begin
            // Arrival numbering: advance, then report.
            state_next.arrival_number = state_cur.arrival_number + {{(LAST_W-1){1'b0}}, 1'b1};
            result.effective_sequence = state_next.arrival_number;
            state_next.accepted_total = sat_inc(state_cur.accepted_total);
        end
        else if (item.is_snapshot)
        begin
            if (!prev_is_none)
            begin
                result.verdict            = VERDICT_GAP;
                result.effective_sequence = last_positive ? state_cur.last_sequence : '0;
                state_next.gap_total      = sat_inc(state_cur.gap_total);
            end
            else
            begin
                state_next.baseline_valid = 1'b1;
                state_next.last_sequence  = seq_ext;
                result.effective_sequence = seq_ext;
                state_next.accepted_total = sat_inc(state_cur.accepted_total);
            end
        end
        else if (!state_cur.baseline_valid)
        begin
            // Drop deltas ahead of the first baseline, uncounted.
            result.verdict = VERDICT_GAP;
        end
        else if (!prev_links)
        begin
            result.verdict            = VERDICT_GAP;
            result.effective_sequence = state_cur.last_sequence;
            state_next.gap_total      = sat_inc(state_cur.gap_total);
        end
        else if ((seq_ext == state_cur.last_sequence) && item.has_levels)
        begin
            result.verdict            = VERDICT_STALE;
            result.effective_sequence = state_cur.last_sequence;
            state_next.stale_total    = sat_inc(state_cur.stale_total);
        end
        else
        begin
            state_next.last_sequence  = seq_ext;
            result.effective_sequence = seq_ext;
            state_next.accepted_total = sat_inc(state_cur.accepted_total);
        end

        result.accepted_count = state_next.accepted_total;
        result.gap_count      = state_next.gap_total;
        result.stale_count    = state_next.stale_total;
    end

endmodule

`default_nettype wire

[sim/feed_sequence_validator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for feed_sequence_validator: directed table, then random feed traffic.

module feed_sequence_validator_tb;

    import fsv_pkg::*;

    localparam logic [SEQ_W-1:0]  SEQ_MAX = '1;
    localparam logic [LAST_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [LAST_W-1:0] NEG_MIN = 64'h8000_0000_0000_0000;
    localparam int                HOLDOFF_CYCLES = 60;
    localparam int                DIR_ROWS = 23;

    // One line of the directed table: mode to run it in, the request, and
    // optionally a hand-written expectation (typed = 1) instead of the predictor's.
    typedef struct packed {
        logic    mode;
        item_t   req;
        logic    typed;
        result_t want;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic                     cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     is_snapshot;
    logic [SEQ_W-1:0]         event_sequence;
    logic                     prev_present;
    logic signed [LAST_W-1:0] prev_sequence;
    logic                     has_levels;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               verdict;
    logic [LAST_W-1:0]        effective_sequence;
    logic [CNT_W-1:0]         accepted_count;
    logic [CNT_W-1:0]         gap_count;
    logic [CNT_W-1:0]         stale_count;

    // Shadow of the block's state, advanced once per accepted request.
    logic              mode_q;
    logic              has_baseline;
    logic [LAST_W-1:0] last_seq;
    logic [LAST_W-1:0] arrival_no;
    logic [CNT_W-1:0]  accepted_total;
    logic [CNT_W-1:0]  gap_total;
    logic [CNT_W-1:0]  stale_total;

    result_t pending_verdicts[$];
    result_t head_verdict;
    int      errors;
    int      send_idle_pct;
    int      stall_pct;
    int      holdoff_left;

    // Directed requests, starting from the reset state in sequenced mode.
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        // delta before any baseline: dropped, nothing counted
        '{1'b1, '{1'b0, 63'd5, 1'b1, NO_PREV, 1'b1}, 1'b1,
          '{VERDICT_GAP, 64'd0, 32'd0, 32'd0, 32'd0}},
        '{1'b1, '{1'b0, SEQ_MAX, 1'b0, 64'd0, 1'b0}, 1'b1,
          '{VERDICT_GAP, 64'd0, 32'd0, 32'd0, 32'd0}},
        // malformed snapshots while last sequence is still all ones
        '{1'b1, '{1'b1, 63'd10, 1'b0, NO_PREV, 1'b0}, 1'b1,
          '{VERDICT_GAP, 64'd0, 32'd0, 32'd1, 32'd0}},
        '{1'b1, '{1'b1, 63'd10, 1'b1, 64'd5, 1'b1}, 1'b1,
          '{VERDICT_GAP, 64'd0, 32'd0, 32'd2, 32'd0}},
        // baseline, linked delta, empty keepalive, repeat with levels
        '{1'b1, '{1'b1, 63'd100, 1'b1, NO_PREV, 1'b1}, 1'b1,
          '{VERDICT_ACCEPT, 64'd100, 32'd1, 32'd2, 32'd0}},
        '{1'b1, '{1'b0, 63'd101, 1'b1, 64'd100, 1'b1}, 1'b1,
          '{VERDICT_ACCEPT, 64'd101, 32'd2, 32'd2, 32'd0}},
        '{1'b1, '{1'b0, 63'd101, 1'b1, 64'd101, 1'b0}, 1'b1,
          '{VERDICT_ACCEPT, 64'd101, 32'd3, 32'd2, 32'd0}},
        '{1'b1, '{1'b0, 63'd101, 1'b1, 64'd101, 1'b1}, 1'b1,
          '{VERDICT_STALE, 64'd101, 32'd3, 32'd2, 32'd1}},
        // missing link: prev carried a matching value but is flagged absent
        '{1'b1, '{1'b0, 63'd102, 1'b0, 64'd101, 1'b1}, 1'b1,
          '{VERDICT_GAP, 64'd101, 32'd3, 32'd3, 32'd1}},
        // broken link
        '{1'b1, '{1'b0, 63'd103, 1'b1, 64'd99, 1'b0}, 1'b1,
          '{VERDICT_GAP, 64'd101, 32'd3, 32'd4, 32'd1}},
        // malformed snapshot with a positive last sequence reports it
        '{1'b1, '{1'b1, 63'd7, 1'b1, 64'd0, 1'b0}, 1'b1,
          '{VERDICT_GAP, 64'd101, 32'd3, 32'd5, 32'd1}},
        // sequence extremes
        '{1'b1, '{1'b1, SEQ_MAX, 1'b1, NO_PREV, 1'b0}, 1'b1,
          '{VERDICT_ACCEPT, POS_MAX, 32'd4, 32'd5, 32'd1}},
        '{1'b1, '{1'b0, 63'd0, 1'b1, POS_MAX, 1'b1}, 1'b1,
          '{VERDICT_ACCEPT, 64'd0, 32'd5, 32'd5, 32'd1}},
        // malformed snapshot with last sequence zero reports zero
        '{1'b1, '{1'b1, 63'd1, 1'b1, NEG_MIN, 1'b1}, 1'b1,
          '{VERDICT_GAP, 64'd0, 32'd5, 32'd6, 32'd1}},
        '{1'b1, '{1'b0, 63'd0, 1'b1, 64'd0, 1'b1}, 1'b1,
          '{VERDICT_STALE, 64'd0, 32'd5, 32'd6, 32'd2}},
        '{1'b1, '{1'b1, 63'd0, 1'b1, NO_PREV, 1'b1}, 1'b1,
          '{VERDICT_ACCEPT, 64'd0, 32'd6, 32'd6, 32'd2}},
        '{1'b1, '{1'b0, SEQ_MAX, 1'b1, 64'd0, 1'b0}, 1'b1,
          '{VERDICT_ACCEPT, POS_MAX, 32'd7, 32'd6, 32'd2}},
        '{1'b1, '{1'b0, 63'd1, 1'b0, NO_PREV, 1'b1}, 1'b1,
          '{VERDICT_GAP, POS_MAX, 32'd7, 32'd7, 32'd2}},
        '{1'b1, '{1'b0, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1, POS_MAX, 1'b1}, 1'b0, '0},
        // arrival numbering, then back to sequenced mode with state kept
        '{1'b0, '{1'b1, 63'd42, 1'b0, 64'd0, 1'b1}, 1'b0, '0},
        '{1'b0, '{1'b0, SEQ_MAX, 1'b1, NO_PREV, 1'b0}, 1'b0, '0},
        '{1'b1, '{1'b0, 63'h2AAA_AAAA_AAAA_AAAB, 1'b1, 64'h2AAA_AAAA_AAAA_AAAA, 1'b0},
          1'b0, '0},
        '{1'b1, '{1'b0, 63'h5555_5555_5555_5555, 1'b1, NO_PREV, 1'b1}, 1'b0, '0}
    };

    feed_sequence_validator dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Compute the verdict for one accepted request and advance the shadow state.
    task automatic advance_feed_state(input item_t r, output result_t res);
        logic [LAST_W-1:0] seq;
        seq = {1'b0, r.event_sequence};
        res.verdict = VERDICT_ACCEPT;
        res.effective_sequence = seq;
        if (!mode_q)
        begin
            // arrival mode: number every request, ignore its content
            arrival_no = arrival_no + 1'b1;
            res.effective_sequence = arrival_no;
            accepted_total = bump_count(accepted_total);
        end
        else if (r.is_snapshot)
        begin
            if (!r.prev_present || r.prev_sequence != NO_PREV)
            begin
                // malformed snapshot: report last sequence only when positive
                res.verdict = VERDICT_GAP;
                res.effective_sequence = (last_seq != '0 && !last_seq[LAST_W-1]) ? last_seq : '0;
                gap_total = bump_count(gap_total);
            end
            else
            begin
                has_baseline = 1'b1;
                last_seq = seq;
                accepted_total = bump_count(accepted_total);
            end
        end
        else if (!has_baseline)
        begin
            // drop quietly: no counter moves
            res.verdict = VERDICT_GAP;
            res.effective_sequence = '0;
        end
        else if (!r.prev_present || r.prev_sequence != last_seq)
        begin
            res.verdict = VERDICT_GAP;
            res.effective_sequence = last_seq;
            gap_total = bump_count(gap_total);
        end
        else if (seq == last_seq && r.has_levels)
        begin
            res.verdict = VERDICT_STALE;
            res.effective_sequence = last_seq;
            stale_total = bump_count(stale_total);
        end
        else
        begin
            last_seq = seq;
            accepted_total = bump_count(accepted_total);
        end
        res.accepted_count = accepted_total;
        res.gap_count = gap_total;
        res.stale_count = stale_total;
    endtask

    // Build a random request. In sequenced mode most requests continue the
    // current chain; the rest are snapshots, broken chains and plain noise.
    function automatic item_t make_request();
        item_t r;
        int    kind;
        r.is_snapshot = 1'($urandom_range(1));
        r.event_sequence = SEQ_W'({$urandom, $urandom});
        r.prev_present = 1'($urandom_range(1));
        r.prev_sequence = {$urandom, $urandom};
        r.has_levels = 1'($urandom_range(1));
        kind = $urandom_range(99);
        if (mode_q)
        begin
            if (kind < 55)
            begin
                r.is_snapshot = 1'b0;
                r.prev_present = 1'b1;
                r.prev_sequence = last_seq;
                case ($urandom_range(3))
                    0, 1: r.event_sequence = last_seq[SEQ_W-1:0] + 1'b1;
                    2: r.event_sequence = last_seq[SEQ_W-1:0];
                    default: ;
                endcase
            end
            else if (kind < 67)
            begin
                r.is_snapshot = 1'b1;
                r.prev_present = 1'b1;
                r.prev_sequence = NO_PREV;
                if ($urandom_range(1))
                    r.event_sequence = SEQ_W'($urandom_range(255));
            end
            else if (kind < 75)
            begin
                r.is_snapshot = 1'b1;
                if ($urandom_range(1))
                    r.prev_present = 1'b0;
                else
                    r.prev_sequence = NO_PREV ^ (64'd1 << $urandom_range(63));
            end
            else if (kind < 83)
            begin
                r.is_snapshot = 1'b0;
                r.prev_present = 1'b0;
                if ($urandom_range(1))
                    r.prev_sequence = last_seq;
            end
            else if (kind < 91)
            begin
                r.is_snapshot = 1'b0;
                r.prev_present = 1'b1;
                r.prev_sequence = last_seq ^ (64'd1 << $urandom_range(63));
            end
        end
        return r;
    endfunction

    // Offer one request, hold it until accepted, then record its expected verdict.
    // Returns at the rising edge that took the request.
    task automatic send_request(input item_t r, input logic typed, input result_t typed_res);
        result_t res;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid       <= 1'b1;
        is_snapshot    <= r.is_snapshot;
        event_sequence <= r.event_sequence;
        prev_present   <= r.prev_present;
        prev_sequence  <= r.prev_sequence;
        has_levels     <= r.has_levels;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_feed_state(r, res);
        pending_verdicts.insert(pending_verdicts.size(), typed ? typed_res : res);
    endtask

    // Drop valid and wait until every outstanding verdict has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Write validation_mode; only call with the pipeline drained.
    task automatic write_mode(input logic m);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        mode_q = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Receiver: stall at random, or hold off for a fixed stretch when asked.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_left > 0)
            begin
                out_stall <= 1'b1;
                holdoff_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Result checker: match every delivered verdict against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, got verdict %0d seq %h",
                         $time, verdict, effective_sequence);
            end
            else
            begin
                head_verdict = pending_verdicts.pop_front();
                compare_field("verdict", 64'(head_verdict.verdict), 64'(verdict));
                compare_field("effective_sequence", head_verdict.effective_sequence,
                              effective_sequence);
                compare_field("accepted_count", 64'(head_verdict.accepted_count),
                              64'(accepted_count));
                compare_field("gap_count", 64'(head_verdict.gap_count), 64'(gap_count));
                compare_field("stale_count", 64'(head_verdict.stale_count),
                              64'(stale_count));
            end
        end
    end

    // Main sequence: reset, directed table, then four phases of random traffic with different idle and stall rates.
    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        holdoff_left = 0;
        mode_q = 1'b1;
        has_baseline = 1'b0;
        last_seq = NO_PREV;
        arrival_no = '0;
        accepted_total = '0;
        gap_total = '0;
        stale_total = '0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        is_snapshot = 1'b0;
        event_sequence = '0;
        prev_present = 1'b0;
        prev_sequence = '0;
        has_levels = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(1'b1);

        // Walk the directed table; switch mode only once the pipeline is empty.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].mode != mode_q)
            begin
                drain_results();
                write_mode(dir_rows[i].mode);
            end
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            drain_results();
            write_mode(1'b1);
            for (int n = 0; n < 130; n++)
            begin
                send_request(make_request(), 1'b0, '0);
                // Hold off the receiver while requests keep coming, so the
                // pipeline fills and the input stalls.
                if (p == 0 && n == 20)
                    holdoff_left = HOLDOFF_CYCLES;
                // Pause the sender until every verdict is back.
                if (p == 0 && n == 70)
                    drain_results();
            end
            drain_results();
            write_mode(1'b0);
            for (int n = 0; n < 30; n++)
                send_request(make_request(), 1'b0, '0);
        end

        drain_results();
        // Keep watching for stray results.
        repeat (8)
            @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
